FILE: design/qr_data_mask_unmask_defines.svh
// Assertion macros for the QR data mask remover.
`ifndef QR_DATA_MASK_UNMASK_DEFINES_SVH
`define QR_DATA_MASK_UNMASK_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define QDM_ASSERT_SAME(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define QDM_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: design/qdm_pkg.sv
// Package with the types, constants and position tables of the QR data mask remover.
`default_nettype none

package qdm_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam logic [7:0]  MAX_SIZE  = 8'd177;
  localparam logic [7:0]  RESET_SIZE = 8'd21;

  typedef enum logic [2:0] {
    MASK_EVEN_INDEX,
    MASK_EVEN_COL,
    MASK_ROW3,
    MASK_DIAG3,
    MASK_BLOCK,
    MASK_PROD6,
    MASK_PROD_MIX,
    MASK_DIAG_PROD
  } mask_rule_t;

  typedef enum logic {
    REG_MASK_PATTERN,
    REG_SYMBOL_SIZE
  } reg_index_t;

  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
    logic       valid;
  } init_t;

  typedef init_t [WORD_BITS-1:0] init_row_t;
  typedef init_row_t [WORD_BITS-1:0] init_tab_t;

  typedef struct packed {
    logic [5:0] rows;
    logic [5:0] cols;
  } step_t;

  typedef step_t [WORD_BITS:0] step_tab_t;

  typedef struct packed {
    mask_rule_t rule;
    logic [7:0] size;
    logic [5:0] step_rows;
    logic [5:0] step_cols;
  } lane_cfg_t;

  typedef struct packed {
    logic flip;
    logic valid;
    logic last_cell;
  } lane_stat_t;

  typedef struct packed {
    logic [6:0] div;
    logic [1:0] rem;
  } div3_t;

  // Start position of each lane for symbols narrower than a word.
  function automatic init_tab_t build_init_tab();
    init_tab_t tab;
    int        c;
    int        r;
    tab = '0;
    for (int s = 1; s < WORD_BITS; s++) begin
      c = 0;
      r = 0;
      for (int n = 0; n < WORD_BITS; n++) begin
        tab[s][n].col   = 8'(c);
        tab[s][n].row   = 8'(r);
        tab[s][n].valid = (r < s);
        c++;
        if (c == s) begin
          c = 0;
          r++;
        end
      end
    end
    return tab;
  endfunction

  // Rows and columns that one word moves a lane forward.
  function automatic step_tab_t build_step_tab();
    step_tab_t tab;
    int        quo_v;
    int        rem_v;
    tab = '0;
    for (int s = 1; s <= WORD_BITS; s++) begin
      quo_v = 0;
      rem_v = WORD_BITS;
      while (rem_v >= s) begin
        rem_v = rem_v - s;
        quo_v++;
      end
      tab[s].rows = 6'(quo_v);
      tab[s].cols = 6'(rem_v);
    end
    return tab;
  endfunction

  localparam init_tab_t INIT_TAB = build_init_tab();
  localparam step_tab_t STEP_TAB = build_step_tab();

  // Quotient and remainder by three of an 8-bit value, via a reciprocal multiply.
  function automatic div3_t div_by3(input logic [7:0] v);
    logic [15:0] prod;
    logic [6:0]  quo;
    logic [7:0]  back;
    div3_t       res;
    prod     = 16'(v) * 16'd171;
    quo      = prod[15:9];
    back     = {quo, 1'b0} + {1'b0, quo};
    res.div  = quo;
    res.rem  = 2'(v - back);
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: design/qdm_lane.sv
// One cell lane: tracks its cell position across words and evaluates the mask rule.
`default_nettype none

module qdm_lane
  import qdm_pkg::*;
#(
  parameter int unsigned LANE = 0
) (
  input  wire logic       clk,
  input  wire logic       adv_en,
  input  wire logic       restart,
  input  wire lane_cfg_t  cfg,
  output lane_stat_t      stat
);

  localparam logic EVEN_LANE = ((LANE % 2) == 0);

  logic [7:0] col_r, col_nxt;
  logic [7:0] row_r, row_nxt;
  logic       valid_r, valid_nxt;

  init_t      init_pos;
  logic [7:0] cur_col;
  logic [7:0] cur_row;
  logic       cur_valid;
  logic [8:0] col_sum;
  logic [8:0] row_sum;
  logic       col_wrap;

  div3_t      col_d3;
  div3_t      row_d3;
  logic       prod_odd;
  logic [1:0] prod_m3;
  logic [2:0] diag_sum;
  logic       diag_m3_zero;
  logic       marked;

  always_comb begin
    if (cfg.size >= 8'(WORD_BITS)) begin
      init_pos.col   = 8'(LANE);
      init_pos.row   = 8'd0;
      init_pos.valid = 1'b1;
    end else begin
      init_pos = INIT_TAB[cfg.size[4:0]][LANE];
    end
  end

  assign cur_col   = restart ? init_pos.col   : col_r;
  assign cur_row   = restart ? init_pos.row   : row_r;
  assign cur_valid = restart ? init_pos.valid : valid_r;

  always_comb begin
    col_sum   = {1'b0, cur_col} + 9'(cfg.step_cols);
    col_wrap  = (col_sum >= {1'b0, cfg.size});
    col_nxt   = col_wrap ? 8'(col_sum - {1'b0, cfg.size}) : col_sum[7:0];
    row_sum   = {1'b0, cur_row} + 9'(cfg.step_rows) + 9'(col_wrap);
    row_nxt   = row_sum[7:0];
    valid_nxt = (row_sum < {1'b0, cfg.size});
  end

  always_ff @(posedge clk) begin
    if (adv_en) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_comb begin
    col_d3       = div_by3(cur_col);
    row_d3       = div_by3(cur_row);
    prod_odd     = cur_col[0] & cur_row[0];
    if ((col_d3.rem == 2'd0) || (row_d3.rem == 2'd0)) begin
      prod_m3 = 2'd0;
    end else if (col_d3.rem == row_d3.rem) begin
      prod_m3 = 2'd1;
    end else begin
      prod_m3 = 2'd2;
    end
    diag_sum     = {1'b0, col_d3.rem} + {1'b0, row_d3.rem};
    diag_m3_zero = (diag_sum == 3'd0) || (diag_sum == 3'd3);

    case (cfg.rule)
      MASK_EVEN_INDEX: marked = EVEN_LANE;
      MASK_EVEN_COL:   marked = ~cur_col[0];
      MASK_ROW3:       marked = (row_d3.rem == 2'd0);
      MASK_DIAG3:      marked = diag_m3_zero;
      MASK_BLOCK:      marked = (cur_col[1] == row_d3.div[0]);
      MASK_PROD6:      marked = ~prod_odd && (prod_m3 == 2'd0);
      MASK_PROD_MIX:   marked = ~(prod_odd ^ prod_m3[0]);
      MASK_DIAG_PROD:  marked = ~(cur_col[0] ^ cur_row[0] ^ prod_m3[0]);
      default:         marked = 1'b0;
    endcase
  end

  assign stat.flip      = marked & cur_valid;
  assign stat.valid     = cur_valid;
  assign stat.last_cell = cur_valid && (cur_col == 8'(cfg.size - 8'd1)) &&
                          (cur_row == 8'(cfg.size - 8'd1));

endmodule

`default_nettype wire

FILE: design/qr_data_mask_unmask.sv
// Top level of the QR data mask remover: configuration registers, cell lanes and output stage.
// The block removes a QR data mask from a symbol streamed as 32-cell words, least
// significant bit first. Unless stalled, it takes one word per clock cycle, returning one
// word for each transfer in the cycle after it is taken; an output register sits between
// the channels, so a new word enters as the last result leaves; the input stalls only while
// the output is both full and stalled. The rate is set by 32 parallel cell lanes, each of
// which keeps its own cell position in registers and evaluates the mask rule for its bit
// in the cycle the word arrives; the lane results are merged into the output word and the
// last-word flag. Writing either register returns the position to the first cell, and the
// symbol restarts after each word that holds its final cell. No clearing pass is needed.
`default_nettype none
`include "qr_data_mask_unmask_defines.svh"

module qr_data_mask_unmask
  import qdm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_masked_word,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [31:0] out_unmasked_word,
  output logic             out_last_word
);

  mask_rule_t  mask_r, mask_nxt;
  logic [7:0]  size_r, size_nxt;
  logic        restart_r, restart_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_word_r;
  logic        out_last_r;

  logic        cfg_write;
  reg_index_t  cfg_index;
  logic        in_take;
  logic [7:0]  eff_size;
  step_t       step;
  lane_cfg_t   lane_cfg;
  lane_stat_t  lane_stat [WORD_BITS];
  logic [WORD_BITS-1:0] flip_vec;
  logic        word_last;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_t'(paddr[2]);

  always_comb begin
    case (cfg_index)
      REG_MASK_PATTERN: prdata = {29'd0, mask_r};
      REG_SYMBOL_SIZE:  prdata = {24'd0, size_r};
      default:          prdata = 32'd0;
    endcase
  end

  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    if (size_r == 8'd0) begin
      eff_size = 8'd1;
    end else if (size_r > MAX_SIZE) begin
      eff_size = MAX_SIZE;
    end else begin
      eff_size = size_r;
    end
    if (eff_size <= 8'(WORD_BITS)) begin
      step = STEP_TAB[eff_size[5:0]];
    end else begin
      step.rows = 6'd0;
      step.cols = 6'(WORD_BITS);
    end
  end

  assign lane_cfg.rule      = mask_r;
  assign lane_cfg.size      = eff_size;
  assign lane_cfg.step_rows = step.rows;
  assign lane_cfg.step_cols = step.cols;

  for (genvar g = 0; g < WORD_BITS; g++) begin : g_lane
    qdm_lane #(
      .LANE (g)
    ) u_lane (
      .clk     (clk),
      .adv_en  (in_take),
      .restart (restart_r),
      .cfg     (lane_cfg),
      .stat    (lane_stat[g])
    );
    assign flip_vec[g] = lane_stat[g].flip;
  end

  assign word_last = !lane_stat[WORD_BITS-1].valid || lane_stat[WORD_BITS-1].last_cell;

  always_comb begin
    mask_nxt      = mask_r;
    size_nxt      = size_r;
    restart_nxt   = restart_r;
    out_valid_nxt = out_valid_r;
    if (in_take) begin
      restart_nxt   = word_last;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_write) begin
      restart_nxt = 1'b1;
      case (cfg_index)
        REG_MASK_PATTERN: mask_nxt = mask_rule_t'(pwdata[2:0]);
        REG_SYMBOL_SIZE:  size_nxt = pwdata[7:0];
        default:          mask_nxt = mask_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= MASK_EVEN_INDEX;
      size_r      <= RESET_SIZE;
      restart_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      size_r      <= size_nxt;
      restart_r   <= restart_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_word_r <= in_masked_word ^ flip_vec;
      out_last_r <= word_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_unmasked_word = out_word_r;
  assign out_last_word     = out_last_r;

  `QDM_ASSERT_SAME(a_stall_when_full, out_valid_r && out_stall, in_stall, "input not stalled while output held")
  `QDM_ASSERT_NEXT(a_cfg_restarts, cfg_write, restart_r, "register write did not restart the symbol")
  `QDM_ASSERT_NEXT(a_last_restarts, in_take && word_last && !cfg_write, restart_r && out_last_word, "final word did not restart the symbol")
  `QDM_ASSERT_NEXT(a_take_fills_output, in_take, out_valid, "transfer taken but no result shown")

endmodule

`default_nettype wire
